/* hw/rtl/cgl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_pkg: shared types and constants for the gradient table entry block
// Register map, stop layout, divider request/response and sequencer states.
// ----------------------------------------------------------------------------
package cgl_pkg;

  localparam int unsigned MAX_STOPS_DEF      = 4;
  localparam int unsigned MAX_TABLE_SIZE_DEF = 4096;

  localparam int unsigned NUM_STOP_REGS = 4;
  localparam int unsigned SIZE_REG_W    = 13;
  localparam int unsigned COUNT_W       = 3;
  localparam int unsigned INDEX_W       = 12;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned POS_W         = FRAC_W + 1;
  localparam int unsigned SIZE_W        = 17;
  localparam int unsigned DIV_W         = 17;
  localparam int unsigned DIV_STEPS     = FRAC_W + 1;
  localparam int unsigned ADDR_W        = 6;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned STOP_W        = POS_W + 3 * CHAN_W;

  localparam logic [POS_W-1:0] Q16_ONE = POS_W'(1) << FRAC_W;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } stop_t;

  typedef struct packed {
    logic [SIZE_REG_W-1:0]          table_size;
    logic [COUNT_W-1:0]             stop_count;
    stop_t [NUM_STOP_REGS-1:0]      stops;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    REG_TABLE_SIZE = 3'd0,
    REG_STOP_COUNT = 3'd1,
    REG_STOP_ZERO  = 3'd2,
    REG_STOP_ONE   = 3'd3,
    REG_STOP_TWO   = 3'd4,
    REG_STOP_THREE = 3'd5
  } reg_addr_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VDIV,
    ST_SEARCH,
    ST_MDIV,
    ST_MUL,
    ST_ADD,
    ST_PUSH
  } seq_state_e;

  localparam logic [SIZE_REG_W-1:0] TABLE_SIZE_RST = SIZE_REG_W'(256);
  localparam logic [COUNT_W-1:0]    STOP_COUNT_RST = COUNT_W'(2);
  localparam stop_t STOP_ZERO_RST  = STOP_W'(0);
  localparam stop_t STOP_ONE_RST   = 41'h100_00FF_FFFF;
  localparam stop_t STOP_TWO_RST   = STOP_W'(0);
  localparam stop_t STOP_THREE_RST = STOP_W'(0);

  function automatic logic [CHAN_W-1:0] stop_chan(input stop_t s, input logic [1:0] ch);
    logic [CHAN_W-1:0] c;
    case (ch)
      2'd0:    c = s.red;
      2'd1:    c = s.green;
      default: c = s.blue;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/color_gradient_lut_entry.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_gradient_lut_entry: RGB color of one gradient table entry
// Maps a table index to a Q16 position, walks the color stops and blends
// the two neighboring stops with a shared divider and multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  --------  ---------  ---------------------------  --------------------------
//  request   in         in_valid_i / in_ready_o      entry_index_i
//  result    out        out_valid_o / out_ready_i    red_o, green_o, blue_o
//  config    in/out     psel, penable, pwrite/pready paddr, pwdata, prdata
//
//  Index 0 goes straight to the output step; a clamped entry runs the
//  position divide and the stop walk; a blended entry also runs the mix
//  divide and one multiply/add pair per channel, using the shared 17-step
//  divider twice (position, then mix factor).
//  Reset clears sequencer and output valid; no clearing pass is needed.
//  A held result does not block the next request: the sequencer only waits
//  in its final step until the output register is free.
//
module color_gradient_lut_entry
  import cgl_pkg::*;
#(
  parameter int unsigned MAX_STOPS      = MAX_STOPS_DEF,
  parameter int unsigned MAX_TABLE_SIZE = MAX_TABLE_SIZE_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [INDEX_W-1:0] entry_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [CHAN_W-1:0]  red_o,
  output logic      [CHAN_W-1:0]  green_o,
  output logic      [CHAN_W-1:0]  blue_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  localparam logic [SIZE_W-1:0]  MAX_SIZE  = SIZE_W'(MAX_TABLE_SIZE);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_STOPS);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  seq_state_e state_q, state_d;

  logic [POS_W-1:0]          v_q, v_d;
  logic [COUNT_W-1:0]        k_q, k_d;
  stop_t                     lo_q, lo_d, hi_q, hi_d;
  logic [FRAC_W-1:0]         mix_q, mix_d;
  logic [1:0]                ch_q, ch_d;
  logic signed [25:0]        prod_q, prod_d;
  logic [2:0][CHAN_W-1:0]    res_q, res_d;
  logic [2:0][CHAN_W-1:0]    out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic [SIZE_W-1:0]  size_eff;
  logic [SIZE_W-1:0]  idx_eff;
  logic [COUNT_W-1:0] count_eff;

  cgl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cgl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Clamp table size, entry index and stop count into their usable ranges.
  always_comb begin
    size_eff = SIZE_W'(cfg.table_size);
    if (size_eff > MAX_SIZE) begin
      size_eff = MAX_SIZE;
    end
    if (size_eff < SIZE_W'(3)) begin
      size_eff = SIZE_W'(3);
    end
    idx_eff = SIZE_W'(entry_index_i);
    if (idx_eff >= size_eff) begin
      idx_eff = size_eff - SIZE_W'(1);
    end
    count_eff = cfg.stop_count;
    if (count_eff == '0) begin
      count_eff = COUNT_W'(1);
    end
    if (count_eff > MAX_COUNT) begin
      count_eff = MAX_COUNT;
    end
  end

  // Sequencer: position divide, stop walk, mix divide, three blend steps.
  always_comb begin
    stop_t             cur;
    logic signed [8:0] diff;
    logic signed [9:0] sum;

    state_d     = state_q;
    v_d         = v_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mix_d       = mix_q;
    ch_d        = ch_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_req     = '0;

    cur  = cfg.stops[k_q[1:0]];
    diff = $signed({1'b0, stop_chan(hi_q, ch_q)}) - $signed({1'b0, stop_chan(lo_q, ch_q)});
    sum  = $signed({2'b00, stop_chan(lo_q, ch_q)}) + $signed(prod_q[25:16]);

    // Drop the held result once the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (idx_eff == '0) begin
            res_d   = '0;
            state_d = ST_PUSH;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(idx_eff - SIZE_W'(1));
            div_req.divisor  = DIV_W'(size_eff - SIZE_W'(2));
            state_d          = ST_VDIV;
          end
        end
      end
      ST_VDIV: begin
        if (div_rsp.done) begin
          v_d     = div_rsp.quotient;
          k_d     = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (k_q == count_eff) begin
          // Past the last stop: hold the last stop's color.
          res_d   = {lo_q.blue, lo_q.green, lo_q.red};
          state_d = ST_PUSH;
        end else if (cur.pos > v_q) begin
          if (k_q == '0) begin
            res_d   = {cur.blue, cur.green, cur.red};
            state_d = ST_PUSH;
          end else begin
            hi_d             = cur;
            div_req.start    = 1'b1;
            div_req.dividend = v_q - lo_q.pos;
            div_req.divisor  = cur.pos - lo_q.pos;
            state_d          = ST_MDIV;
          end
        end else begin
          lo_d = cur;
          k_d  = k_q + COUNT_W'(1);
        end
      end
      ST_MDIV: begin
        if (div_rsp.done) begin
          mix_d   = div_rsp.quotient[FRAC_W-1:0];
          ch_d    = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = $signed({1'b0, mix_q}) * diff;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        res_d[ch_q] = sum[CHAN_W-1:0];
        if (ch_q == 2'd2) begin
          state_d = ST_PUSH;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_PUSH: begin
        // Advance only when the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    k_q    <= k_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mix_q  <= mix_d;
    ch_q   <= ch_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

  // An accepted request always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after accepting a request");

  // The divider only finishes while the sequencer waits on it.
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_VDIV || state_q == ST_MDIV))
    else $error("divider finished outside a divide step");

  // Table position never passes 1.0.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VDIV && div_rsp.done |-> div_rsp.quotient <= Q16_ONE)
    else $error("table position above 1.0");

  // Mix factor stays strictly below 1.0.
  a_mix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MDIV && div_rsp.done |-> !div_rsp.quotient[FRAC_W])
    else $error("mix factor reached 1.0");

endmodule
`default_nettype wire

/* hw/rtl/cgl_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_regs: configuration register file
// APB-style write/read of table size, stop count and four color stops.
// ----------------------------------------------------------------------------
module cgl_regs
  import cgl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t      cfg_q;
  reg_addr_e addr;
  logic      wr_en;

  assign addr   = reg_addr_e'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_size <= TABLE_SIZE_RST;
      cfg_q.stop_count <= STOP_COUNT_RST;
      cfg_q.stops[0]   <= STOP_ZERO_RST;
      cfg_q.stops[1]   <= STOP_ONE_RST;
      cfg_q.stops[2]   <= STOP_TWO_RST;
      cfg_q.stops[3]   <= STOP_THREE_RST;
    end else if (wr_en) begin
      case (addr)
        REG_TABLE_SIZE: cfg_q.table_size <= pwdata[SIZE_REG_W-1:0];
        REG_STOP_COUNT: cfg_q.stop_count <= pwdata[COUNT_W-1:0];
        REG_STOP_ZERO:  cfg_q.stops[0]   <= pwdata[STOP_W-1:0];
        REG_STOP_ONE:   cfg_q.stops[1]   <= pwdata[STOP_W-1:0];
        REG_STOP_TWO:   cfg_q.stops[2]   <= pwdata[STOP_W-1:0];
        REG_STOP_THREE: cfg_q.stops[3]   <= pwdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (addr)
      REG_TABLE_SIZE: prdata = DATA_W'(cfg_q.table_size);
      REG_STOP_COUNT: prdata = DATA_W'(cfg_q.stop_count);
      REG_STOP_ZERO:  prdata = DATA_W'(cfg_q.stops[0]);
      REG_STOP_ONE:   prdata = DATA_W'(cfg_q.stops[1]);
      REG_STOP_TWO:   prdata = DATA_W'(cfg_q.stops[2]);
      REG_STOP_THREE: prdata = DATA_W'(cfg_q.stops[3]);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/cgl_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgl_div: shared restoring divider for Q16 fractions
// Computes floor(dividend * 65536 / divisor), one quotient bit per cycle.
// Dividend must not exceed the divisor.
// ----------------------------------------------------------------------------
module cgl_div
  import cgl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] den_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   rem_d;
  logic             qbit;

  // First step checks the integer bit without a shift.
  always_comb begin
    trial = (cnt_q == '0) ? rem_q : {rem_q[DIV_W-1:0], 1'b0};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? (trial - {1'b0, den_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.dividend};
      den_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], qbit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire
